// ===== rtl/spad_pkg.sv =====
// ----------------------------------------------------------------------------
// spad_pkg
// Shared widths, register indexes and reset values of the sweep pulse angle
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package spad_pkg;

  // history depth and fill counter
  localparam int HIST_DEPTH = 11;
  localparam int FILL_W     = 4;

  // field widths
  localparam int FIELD_W    = 32;
  localparam int ANGLE_FRAC = 16;

  // stream and config port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_GAP_MIN  = 8'd0,
    CFG_SHORT_GAP_MAX = 8'd1,
    CFG_ANGLE_SCALE   = 8'd2
  } cfg_idx_t;

  // register reset values
  localparam logic [FIELD_W-1:0] LONG_GAP_RST  = 32'd168000;
  localparam logic [FIELD_W-1:0] SHORT_GAP_RST = 32'd1200;
  localparam logic [FIELD_W-1:0] SCALE_RST     = 32'd3865470;

endpackage

`default_nettype wire

// ===== rtl/spad_cell.sv =====
// ----------------------------------------------------------------------------
// spad_cell
// One entry of the edge history row: holds a timestamp, takes its newer
// neighbor's value on a shift and reports the gap to that neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spad_cell #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  shift_en,
  input  wire logic [TIME_WIDTH-1:0] shift_in,
  output logic      [TIME_WIDTH-1:0] value,
  output logic      [TIME_WIDTH-1:0] gap
);

  logic [TIME_WIDTH-1:0] value_r;

  // stored timestamp, moves one place older on every shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value_r <= shift_in;
    end
  end

  // gap to the newer neighbor, modulo the timer width
  assign gap   = shift_in - value_r;
  assign value = value_r;

endmodule

`default_nettype wire

// ===== rtl/spad_scale.sv =====
// ----------------------------------------------------------------------------
// spad_scale
// Angle scaler: registered gap times scale product, then a shift by the
// fraction width with saturation to the angle field.
// ----------------------------------------------------------------------------
`default_nettype none

module spad_scale #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           load,
  input  wire logic [TIME_WIDTH-1:0]          gap,
  input  wire logic [spad_pkg::FIELD_W-1:0]   scale,
  output logic      [spad_pkg::FIELD_W-1:0]   angle
);

  import spad_pkg::*;

  localparam int HI_W  = (TIME_WIDTH > FIELD_W) ? TIME_WIDTH - FIELD_W : 1;
  localparam int PL_W  = 2 * FIELD_W;
  localparam int PH_W  = HI_W + FIELD_W;
  localparam int SUM_W = PL_W - ANGLE_FRAC + 1;

  logic [FIELD_W-1:0] gap_lo;
  logic [HI_W-1:0]    gap_hi;
  logic [PL_W-1:0]    prod_lo_r;
  logic [PH_W-1:0]    prod_hi_r;
  logic [SUM_W-1:0]   sum;
  logic               hi_big;

  // split the gap into a low word and the bits above it
  assign gap_lo = FIELD_W'(gap);
  generate
    if (TIME_WIDTH > FIELD_W) begin : g_wide
      assign gap_hi = gap[TIME_WIDTH-1:FIELD_W];
    end else begin : g_narrow
      assign gap_hi = '0;
    end
  endgenerate

  // partial products, registered
  always_ff @(posedge clk) begin
    if (load) begin
      prod_lo_r <= PL_W'(gap_lo) * PL_W'(scale);
      prod_hi_r <= PH_W'(gap_hi) * PH_W'(scale);
    end
  end

  // recombine, drop the fraction bits and saturate
  assign hi_big = |prod_hi_r[PH_W-1:ANGLE_FRAC];
  assign sum    = SUM_W'({prod_hi_r[ANGLE_FRAC-1:0], {ANGLE_FRAC{1'b0}}})
                + SUM_W'(prod_lo_r[PL_W-1:ANGLE_FRAC]);
  assign angle  = (hi_big || (|sum[SUM_W-1:FIELD_W])) ? '1 : sum[FIELD_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/sweep_pulse_angle_decoder_top.sv =====
// ----------------------------------------------------------------------------
// sweep_pulse_angle_decoder_top
// Sweep pulse angle decoder: edge history row, pattern check and angle
// scaling behind stream ports.
// ----------------------------------------------------------------------------
// Takes one edge timestamp per transfer, one transfer per clock at full rate.
// The timestamp shifts into a row of eleven cells; each cell reports the gap
// to its newer neighbor, so the sync/sweep pattern check of an edge is done
// in the cycle it is taken, with one subtract and compare per gap. The first
// eleven timestamps after reset only fill the row. A matching edge gives one
// result, which passes the check register, product register and output
// register in turn; a non-matching edge gives none. The 32 by 32 partial
// products of the two angle scalers set the longest path. Output stalls back
// up into in_tready only once all three stages hold results.
// ----------------------------------------------------------------------------
`default_nettype none

module sweep_pulse_angle_decoder_top #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // edge input: [31:0] edge_time
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [spad_pkg::IN_TDATA_W-1:0]   in_tdata,
  // result output: [31:0] horizontal_angle, [63:32] vertical_angle,
  // [64] led_state, [71:65] zero
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [spad_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // configuration write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [spad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spad_pkg::FIELD_W-1:0]      cfg_data
);

  import spad_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > FIELD_W) ? TIME_WIDTH : FIELD_W;
  localparam int PAD_W = OUT_TDATA_W - 2 * FIELD_W - 1;

  logic [FIELD_W-1:0]    long_gap_min_r;
  logic [FIELD_W-1:0]    short_gap_max_r;
  logic [FIELD_W-1:0]    angle_scale_r;

  logic [TIME_WIDTH-1:0] edge_in;
  logic [TIME_WIDTH-1:0] cell_in  [HIST_DEPTH];
  logic [TIME_WIDTH-1:0] cell_q   [HIST_DEPTH];
  logic [TIME_WIDTH-1:0] cell_gap [HIST_DEPTH];

  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic                  indicator_r, indicator_nxt;
  logic                  in_xfer;
  logic                  fill_full;
  logic                  match;

  logic                  s1_valid_r;
  logic [TIME_WIDTH-1:0] s1_gap_h_r;
  logic [TIME_WIDTH-1:0] s1_gap_v_r;
  logic                  s1_led_r;
  logic                  s1_ready;

  logic                  s2_valid_r;
  logic                  s2_led_r;
  logic                  s2_ready;
  logic [FIELD_W-1:0]    angle_h;
  logic [FIELD_W-1:0]    angle_v;

  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                  out_ready_int;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_gap_min_r  <= LONG_GAP_RST;
      short_gap_max_r <= SHORT_GAP_RST;
      angle_scale_r   <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LONG_GAP_MIN:  long_gap_min_r  <= cfg_data;
        CFG_SHORT_GAP_MAX: short_gap_max_r <= cfg_data;
        CFG_ANGLE_SCALE:   angle_scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // history row, oldest in cell 0, newest enters cell HIST_DEPTH-1
  assign in_xfer = in_tvalid && in_tready;
  assign edge_in = TIME_WIDTH'(in_tdata[FIELD_W-1:0]);

  generate
    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
      if (k == HIST_DEPTH - 1) begin : g_head
        assign cell_in[k] = edge_in;
      end else begin : g_body
        assign cell_in[k] = cell_q[k+1];
      end
      spad_cell #(
        .TIME_WIDTH(TIME_WIDTH)
      ) u_cell (
        .clk      (clk),
        .shift_en (in_xfer),
        .shift_in (cell_in[k]),
        .value    (cell_q[k]),
        .gap      (cell_gap[k])
      );
    end
  endgenerate

  // pattern check on the history as it stands after this shift:
  // cell k's gap is the gap between entries k and k-1 after the shift
  assign fill_full = (fill_r == FILL_W'(HIST_DEPTH));
  assign match = fill_full
              && (CMP_W'(cell_gap[1])  > CMP_W'(long_gap_min_r))
              && (CMP_W'(cell_gap[3])  > CMP_W'(long_gap_min_r))
              && (CMP_W'(cell_gap[6])  < CMP_W'(short_gap_max_r))
              && (CMP_W'(cell_gap[10]) < CMP_W'(short_gap_max_r));

  // fill counter and indicator
  always_comb begin
    fill_nxt      = fill_r;
    indicator_nxt = indicator_r;
    if (in_xfer) begin
      if (!fill_full) begin
        fill_nxt = fill_r + 1'b1;
      end else if (match) begin
        indicator_nxt = !indicator_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      indicator_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      indicator_r <= indicator_nxt;
    end
  end

  // stage ready chain
  assign out_ready_int = !out_valid_r || out_tready;
  assign s2_ready      = !s2_valid_r || out_ready_int;
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign in_tready     = s1_ready;

  // check register: gaps of a matching edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_xfer && match;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_gap_h_r <= cell_gap[5];
      s1_gap_v_r <= cell_gap[9];
      s1_led_r   <= indicator_nxt;
    end
  end

  // product stage
  spad_scale #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_scale_h (
    .clk   (clk),
    .load  (s2_ready),
    .gap   (s1_gap_h_r),
    .scale (angle_scale_r),
    .angle (angle_h)
  );

  spad_scale #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_scale_v (
    .clk   (clk),
    .load  (s2_ready),
    .gap   (s1_gap_v_r),
    .scale (angle_scale_r),
    .angle (angle_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_led_r <= s1_led_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready_int) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready_int) begin
      out_tdata_r <= {{PAD_W{1'b0}}, s2_led_r, angle_v, angle_h};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ===== rtl/spad_checker.sv =====
// ----------------------------------------------------------------------------
// spad_checker
// Port-level checks of the sweep pulse angle decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spad_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [spad_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import spad_pkg::*;

  localparam int LED_BIT = 2 * FIELD_W;
  localparam int CNT_W   = FILL_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HIST_DEPTH + 1);

  logic [CNT_W-1:0] in_cnt_r;
  logic             last_led_r;

  // count input transfers up to the first one that can give a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r <= '0;
    end else if (in_tvalid && in_tready && (in_cnt_r != CNT_FULL)) begin
      in_cnt_r <= in_cnt_r + 1'b1;
    end
  end

  // led value of the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_led_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      last_led_r <= out_tdata[LED_BIT];
    end
  end

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // no result before the history has filled and one more edge arrived
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> in_cnt_r == CNT_FULL)
    else $error("result before history filled");

  // the led bit alternates from one result to the next
  a_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> out_tdata[LED_BIT] != last_led_r)
    else $error("led bit did not toggle");

  // input back-pressure only comes from a stalled output
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

endmodule

bind sweep_pulse_angle_decoder_top spad_checker u_spad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/sv/spad_angle_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spad_angle_checker
// Watches the edge, result and config channels of the sweep pulse angle
// decoder. Keeps its own edge row, fill count, indicator and registers,
// predicts the angle result of every matching edge transfer and compares each result
// transfer, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module spad_angle_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // [31:0] edge_time
  input  logic [spad_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] horizontal_angle, [63:32] vertical_angle, [64] led_state,
  // [71:65] zero
  input  logic [spad_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [spad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spad_pkg::FIELD_W-1:0]     cfg_data,
  output int                               mismatch_count,
  output int                               results_pending
);
  import spad_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [FIELD_W-1:0] horiz;
    logic [FIELD_W-1:0] vert;
    logic               led;
  } angle_result_t;

  logic [FIELD_W-1:0] long_gap_min;
  logic [FIELD_W-1:0] short_gap_max;
  logic [FIELD_W-1:0] angle_scale;
  logic [FIELD_W-1:0] edge_row [HIST_DEPTH];
  int                 edges_seen;
  logic               led_bit;
  angle_result_t      angle_q [$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  // gap between two row entries, modulo the timer width
  function automatic logic [FIELD_W-1:0] row_gap(input int newer, input int older);
    return edge_row[newer] - edge_row[older];
  endfunction

  // (gap * scale) >> 16, saturated to the field
  function automatic logic [FIELD_W-1:0] angle_of_gap(input logic [FIELD_W-1:0] gap);
    logic [2*FIELD_W-1:0] prod;
    logic [2*FIELD_W-1:0] shifted;
    prod    = {{FIELD_W{1'b0}}, gap} * {{FIELD_W{1'b0}}, angle_scale};
    shifted = prod >> ANGLE_FRAC;
    if (shifted[2*FIELD_W-1:FIELD_W] != '0) return '1;
    return shifted[FIELD_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    angle_result_t                        want;
    logic [FIELD_W-1:0]                   got_h;
    logic [FIELD_W-1:0]                   got_v;
    logic                                 got_led;
    logic [OUT_TDATA_W-2*FIELD_W-2:0]     got_pad;
    if (!rst_n) begin
      long_gap_min  = LONG_GAP_RST;
      short_gap_max = SHORT_GAP_RST;
      angle_scale   = SCALE_RST;
      for (int k = 0; k < HIST_DEPTH; k++) edge_row[k] = '0;
      edges_seen = 0;
      led_bit    = 1'b0;
      angle_q.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        got_h   = out_tdata[FIELD_W-1:0];
        got_v   = out_tdata[2*FIELD_W-1:FIELD_W];
        got_led = out_tdata[2*FIELD_W];
        got_pad = out_tdata[OUT_TDATA_W-1:2*FIELD_W+1];
        if (angle_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with none expected: h=%h v=%h led=%b",
                     $realtime, got_h, got_v, got_led);
        end else begin
          want = angle_q.pop_front();
          if (got_h !== want.horiz || got_v !== want.vert || got_led !== want.led ||
              got_pad !== '0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: expected h=%h v=%h led=%b pad=0, got h=%h v=%h led=%b pad=%h",
                       $realtime, want.horiz, want.vert, want.led,
                       got_h, got_v, got_led, got_pad);
          end
        end
      end

      // register write, unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LONG_GAP_MIN:  long_gap_min  = cfg_data;
          CFG_SHORT_GAP_MAX: short_gap_max = cfg_data;
          CFG_ANGLE_SCALE:   angle_scale   = cfg_data;
          default: ;
        endcase
      end

      // edge transfer: shift, then fill or check the pattern
      if (in_tvalid && in_tready) begin
        for (int k = 0; k < HIST_DEPTH-1; k++) edge_row[k] = edge_row[k+1];
        edge_row[HIST_DEPTH-1] = in_tdata[FIELD_W-1:0];
        if (edges_seen < HIST_DEPTH) begin
          edges_seen++;
        end else if (row_gap(1, 0) > long_gap_min && row_gap(3, 2) > long_gap_min &&
                     row_gap(6, 5) < short_gap_max && row_gap(10, 9) < short_gap_max) begin
          led_bit    = ~led_bit;
          want.horiz = angle_of_gap(row_gap(5, 4));
          want.vert  = angle_of_gap(row_gap(9, 8));
          want.led   = led_bit;
          angle_q.push_back(want);
        end
      end
    end
    results_pending = angle_q.size();
  end

endmodule

// ===== tb/sv/sweep_pulse_angle_decoder_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sweep_pulse_angle_decoder_top_tb
// Drives edge timestamps and register writes into the sweep pulse angle
// decoder. A few directed frames cover the fill phase, timer wrap, the gap
// thresholds and angle saturation; then phases of random sync/sweep frames,
// broken frames and noise run under different register settings and
// handshake idling. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module sweep_pulse_angle_decoder_top_tb;
  import spad_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_EDGES  = 235;

  // indexes outside the register map
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAST = CFG_IDX_W'(CFG_ANGLE_SCALE + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP  = '1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [FIELD_W-1:0]     cfg_data;

  int mismatch_count;
  int results_pending;
  int cycle_count;
  int edges_sent;
  int send_idle_pct;
  int stall_pct;

  // register values as last written, used to shape frames
  logic [FIELD_W-1:0] long_min_cfg;
  logic [FIELD_W-1:0] short_max_cfg;
  logic [FIELD_W-1:0] cur_edge;
  logic [FIELD_W-1:0] frame_gaps [HIST_DEPTH];

  sweep_pulse_angle_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  spad_angle_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // any gap: small, medium or full range
  function automatic logic [FIELD_W-1:0] free_gap();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 2000);
      1:       return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // gap strictly above the long threshold if one exists, sometimes right on the edge
  function automatic logic [FIELD_W-1:0] sync_gap();
    logic [FIELD_W:0] lo;
    logic [FIELD_W:0] hi;
    if (long_min_cfg == '1) return $urandom;
    lo = long_min_cfg + 1;
    if ($urandom_range(0, 9) == 0) return lo[FIELD_W-1:0];
    hi = lo + (1 << 20);
    if (hi > {1'b0, {FIELD_W{1'b1}}}) hi = {1'b0, {FIELD_W{1'b1}}};
    return $urandom_range(hi[FIELD_W-1:0], lo[FIELD_W-1:0]);
  endfunction

  // gap strictly below the short threshold if one exists, sometimes right on the edge
  function automatic logic [FIELD_W-1:0] pulse_gap();
    if (short_max_cfg == '0) return '0;
    case ($urandom_range(0, 9))
      0:       return short_max_cfg - 1;
      1:       return '0;
      default: return $urandom_range(short_max_cfg - 1, 0);
    endcase
  endfunction

  // one edge transfer, called and returning at a falling edge
  task automatic send_edge(input logic [FIELD_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    edges_sent++;
    @(negedge clk);
  endtask

  // edges spaced by the first len entries of frame_gaps
  task automatic send_gaps(input int len);
    for (int j = 0; j < len; j++) begin
      cur_edge = cur_edge + frame_gaps[j];
      send_edge(cur_edge);
    end
  endtask

  // sync/sweep frame, optionally with one threshold gap pushed to its limit
  task automatic send_frame(input int len, input bit broken);
    for (int j = 0; j < HIST_DEPTH; j++) frame_gaps[j] = free_gap();
    frame_gaps[1]  = sync_gap();
    frame_gaps[3]  = sync_gap();
    frame_gaps[6]  = pulse_gap();
    frame_gaps[10] = pulse_gap();
    if (broken) begin
      case ($urandom_range(0, 3))
        0:       frame_gaps[1]  = long_min_cfg;
        1:       frame_gaps[3]  = long_min_cfg;
        2:       frame_gaps[6]  = short_max_cfg;
        default: frame_gaps[10] = short_max_cfg;
      endcase
    end
    send_gaps(len);
  endtask

  // register write, valid left high for a following write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    case (idx)
      CFG_LONG_GAP_MIN:  long_min_cfg  = val;
      CFG_SHORT_GAP_MAX: short_max_cfg = val;
      default: ;
    endcase
  endtask

  // stop sending, wait for every result, let the pipe run empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // registers and idling for one phase
  task automatic set_phase(input int p);
    idle_mode_t mode;
    case (p)
      1: begin
        cfg_write(CFG_LONG_GAP_MIN, '0);
        cfg_write(CFG_SHORT_GAP_MAX, '1);
        cfg_write(CFG_ANGLE_SCALE, '1);
      end
      2: begin
        cfg_write(CFG_LONG_GAP_MIN, '1);
        cfg_write(CFG_SHORT_GAP_MAX, '0);
        cfg_write(CFG_ANGLE_SCALE, '0);
      end
      4: begin
        cfg_write(CFG_LONG_GAP_MIN, 32'd1000);
        cfg_write(CFG_SHORT_GAP_MAX, 32'd1000000);
        cfg_write(CFG_ANGLE_SCALE, 32'd1 << ANGLE_FRAC);
      end
      5: begin
        cfg_write(CFG_LONG_GAP_MIN, LONG_GAP_RST);
        cfg_write(CFG_SHORT_GAP_MAX, SHORT_GAP_RST);
        cfg_write(CFG_ANGLE_SCALE, SCALE_RST);
        cfg_write(CFG_IDX_PAST, $urandom);
        cfg_write(CFG_IDX_TOP, $urandom);
      end
      6: begin
        cfg_write(CFG_LONG_GAP_MIN, $urandom_range(0, 5000));
        cfg_write(CFG_SHORT_GAP_MAX, $urandom_range(1, 5000));
        cfg_write(CFG_ANGLE_SCALE, 32'd1);
      end
      3, 7: begin
        cfg_write(CFG_LONG_GAP_MIN, $urandom_range(0, 400000));
        cfg_write(CFG_SHORT_GAP_MAX, $urandom_range(1, 100000));
        cfg_write(CFG_ANGLE_SCALE, $urandom);
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    mode = idle_mode_t'(p % 4);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 62; stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 62; end
      IDLE_BOTH: begin send_idle_pct = 35; stall_pct = 35; end
      default:   begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  initial begin : stimulus
    int r;
    int target;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    rst_n         = 1'b0;
    edges_sent    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    long_min_cfg  = LONG_GAP_RST;
    short_max_cfg = SHORT_GAP_RST;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // top timer value, then a matching frame that wraps through zero;
    // its last edge is the first one checked after the fill
    cur_edge = '1;
    send_edge(cur_edge);
    for (int j = 0; j < HIST_DEPTH; j++) frame_gaps[j] = 32'd5;
    frame_gaps[0]  = 32'd1;
    frame_gaps[1]  = LONG_GAP_RST + 1;
    frame_gaps[3]  = LONG_GAP_RST + 1;
    frame_gaps[5]  = '1;
    frame_gaps[6]  = SHORT_GAP_RST - 1;
    frame_gaps[9]  = '0;
    frame_gaps[10] = SHORT_GAP_RST - 1;
    send_gaps(HIST_DEPTH);

    // sync gap equal to the threshold must not match
    for (int j = 0; j < HIST_DEPTH; j++) frame_gaps[j] = 32'd7;
    frame_gaps[1]  = LONG_GAP_RST;
    frame_gaps[3]  = '1;
    frame_gaps[5]  = $urandom;
    frame_gaps[6]  = '0;
    frame_gaps[10] = '0;
    send_gaps(HIST_DEPTH);

    // random phases: mostly frames, some broken, some noise
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_phase(p);
      target = edges_sent + PHASE_EDGES;
      while (edges_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_frame(HIST_DEPTH, $urandom_range(0, 99) < 15);
        end else if (r < 85) begin
          repeat ($urandom_range(1, 4)) begin
            cur_edge = $urandom;
            send_edge(cur_edge);
          end
        end else begin
          send_frame($urandom_range(1, HIST_DEPTH-1), 1'b0);
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
